@@ hw/rtl/midi_input_message_parser_core_assert.svh @@
// ----------------------------------------------------------------------------
// MIDI parser assertion macros
// Clocked assertion shorthands used by the parser checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_INPUT_MESSAGE_PARSER_CORE_ASSERT_SVH
`define MIDI_INPUT_MESSAGE_PARSER_CORE_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define MIDI_MP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("midi parser check failed");

// next-cycle implication on clk_i, off during reset
`define MIDI_MP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("midi parser check failed");

`endif

@@ hw/rtl/midi_mp_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI parser package
// Types, byte codes and helpers shared by the MIDI input parser.
// ----------------------------------------------------------------------------
`default_nettype none

package midi_mp_pkg;

  // parse state
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DATA  = 2'd1,
    MODE_SYSEX = 2'd2
  } parse_mode_e;

  // decoded event kinds
  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_KEY_PRES = 3'd2,
    KIND_CONTROL  = 3'd3,
    KIND_PROGRAM  = 3'd4,
    KIND_CHAN_PRES = 3'd5,
    KIND_BEND     = 3'd6
  } kind_e;

  // system byte codes
  localparam logic [7:0] BYTE_ACT_SENSE   = 8'hFE;
  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_MTC_QFRAME  = 8'hF1;
  localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
  localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
  localparam logic [3:0] NIB_SYSTEM       = 4'hF;

  // channel status high nibbles
  localparam logic [3:0] STAT_NOTE_OFF  = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON   = 4'h9;
  localparam logic [3:0] STAT_KEY_PRES  = 4'hA;
  localparam logic [3:0] STAT_CONTROL   = 4'hB;
  localparam logic [3:0] STAT_PROGRAM   = 4'hC;
  localparam logic [3:0] STAT_CHAN_PRES = 4'hD;
  localparam logic [3:0] STAT_BEND      = 4'hE;

  // note-on with zero velocity reports this release velocity
  localparam logic [13:0] NOTE_OFF_VEL = 14'd64;

  // one decoded event
  typedef struct packed {
    logic [7:0]  synth_tag;
    kind_e       event_kind;
    logic [3:0]  channel;
    logic [7:0]  first_data;
    logic [13:0] event_value;
  } event_t;

  // data bytes that follow a channel status
  function automatic logic [1:0] chan_len(logic [7:0] status);
    logic [1:0] len;
    len = ((status[7:4] == STAT_PROGRAM) || (status[7:4] == STAT_CHAN_PRES)) ? 2'd1 : 2'd2;
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/midi_mp_byte_if.sv @@
// ----------------------------------------------------------------------------
// MIDI byte channel
// Valid/ready channel that carries one received MIDI byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface midi_mp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/midi_mp_event_if.sv @@
// ----------------------------------------------------------------------------
// MIDI event channel
// Valid/ready channel that carries one decoded MIDI event per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface midi_mp_event_if;
  logic        valid;
  logic        ready;
  logic [7:0]  synth_tag;
  logic [2:0]  event_kind;
  logic [3:0]  channel;
  logic [7:0]  first_data;
  logic [13:0] event_value;

  modport source (output valid, output synth_tag, output event_kind, output channel,
                  output first_data, output event_value, input ready);
  modport sink   (input valid, input synth_tag, input event_kind, input channel,
                  input first_data, input event_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/midi_mp_decode.sv @@
// ----------------------------------------------------------------------------
// MIDI message decoder
// Turns a finished channel message into one event; system messages give none.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_mp_decode (
  input  logic [7:0]          status_i,
  input  logic [7:0]          data1_i,
  input  logic [7:0]          data2_i,
  input  logic [7:0]          synth_id_i,
  output logic                hit_o,
  output midi_mp_pkg::event_t event_o
);
  import midi_mp_pkg::*;

  // per-status field selection
  always_comb begin
    hit_o                = 1'b1;
    event_o.synth_tag    = synth_id_i;
    event_o.event_kind   = KIND_NOTE_ON;
    event_o.channel      = status_i[3:0];
    event_o.first_data   = data1_i;
    event_o.event_value  = {6'd0, data2_i};
    unique case (status_i[7:4])
      STAT_NOTE_ON: begin
        if (data2_i == 8'd0) begin
          event_o.event_kind  = KIND_NOTE_OFF;
          event_o.event_value = NOTE_OFF_VEL;
        end
      end
      STAT_NOTE_OFF: event_o.event_kind = KIND_NOTE_OFF;
      STAT_KEY_PRES: event_o.event_kind = KIND_KEY_PRES;
      STAT_CONTROL:  event_o.event_kind = KIND_CONTROL;
      STAT_PROGRAM: begin
        event_o.event_kind  = KIND_PROGRAM;
        event_o.event_value = 14'd0;
      end
      STAT_CHAN_PRES: begin
        event_o.event_kind  = KIND_CHAN_PRES;
        event_o.first_data  = 8'd0;
        event_o.event_value = {6'd0, data1_i};
      end
      STAT_BEND: begin
        event_o.event_kind  = KIND_BEND;
        event_o.first_data  = 8'd0;
        event_o.event_value = {data2_i[6:0], data1_i[6:0]};
      end
      default: hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/midi_input_message_parser_core.sv @@
// Path: the last byte of a message is held in the byte register, and its event
//   is then registered in the event register, where it waits for the sink.
// Throughput: one byte per cycle unless the event output stalls; the byte register
//   and the event register form two stages, and the parse state moves as each byte advances.
// Active sensing bytes are dropped at the input register.
// Reset: parser idle, no running status, synth id zero, no event pending.
// ----------------------------------------------------------------------------
// MIDI input message parser core
// Running-status MIDI byte parser that emits one decoded event per channel message.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_input_message_parser_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  midi_mp_byte_if.sink      rx_i,
  midi_mp_event_if.source   ev_o
);
  import midi_mp_pkg::*;

  logic [7:0]  synth_q;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        rx_req;
  logic        advance;

  parse_mode_e mode_q, mode_d;
  logic [1:0]  left_q, left_d;
  logic [1:0]  fill_q, fill_d;
  logic [7:0]  rs_q, rs_d;
  logic [7:0]  buf_q [3];
  logic [7:0]  buf_d [3];

  logic        dec_en;
  logic        dec_hit;
  event_t      dec_ev;

  logic        out_valid_q, out_valid_d;
  event_t      out_ev_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synth_q <= 8'd0;
    end else if (cfg_we_i) begin
      synth_q <= cfg_wdata_i;
    end
  end

  // input handshake
  assign advance    = s1_valid_q && (!out_valid_q || ev_o.ready);
  assign rx_i.ready = !s1_valid_q || advance;
  assign rx_req     = rx_i.valid && rx_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (rx_req) begin
      s1_valid_d = (rx_i.rx_byte != BYTE_ACT_SENSE);
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_req) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  // parse state update
  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    fill_d = fill_q;
    rs_d   = rs_q;
    buf_d  = buf_q;
    dec_en = 1'b0;
    unique case (mode_q)
      MODE_DATA: begin
        if (fill_q != 2'd3) begin
          buf_d[fill_q] = s1_byte_q;
          fill_d        = fill_q + 2'd1;
        end
        if (left_q != 2'd0) begin
          left_d = left_q - 2'd1;
        end
        if (left_d == 2'd0) begin
          mode_d = MODE_IDLE;
          dec_en = 1'b1;
          fill_d = 2'd0;
        end
      end
      MODE_SYSEX: begin
        if (s1_byte_q == BYTE_SYSEX_END) begin
          mode_d = MODE_IDLE;
          left_d = 2'd0;
          fill_d = 2'd0;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        if (s1_byte_q[7]) begin
          if (s1_byte_q[7:4] == NIB_SYSTEM) begin
            if (s1_byte_q == BYTE_SYSEX_START) begin
              mode_d = MODE_SYSEX;
            end else if (s1_byte_q == BYTE_MTC_QFRAME || s1_byte_q == BYTE_SONG_SEL ||
                         s1_byte_q == BYTE_SONG_POS) begin
              mode_d   = MODE_DATA;
              fill_d   = 2'd1;
              left_d   = (s1_byte_q == BYTE_SONG_POS) ? 2'd2 : 2'd1;
              buf_d[0] = s1_byte_q;
            end else begin
              buf_d[0] = s1_byte_q;
              fill_d   = 2'd0;
              left_d   = 2'd0;
            end
          end else begin
            mode_d   = MODE_DATA;
            fill_d   = 2'd1;
            left_d   = chan_len(s1_byte_q);
            buf_d[0] = s1_byte_q;
            rs_d     = s1_byte_q;
          end
        end else if (rs_q[7]) begin
          // running status
          buf_d[0] = rs_q;
          buf_d[1] = s1_byte_q;
          if (chan_len(rs_q) == 2'd1) begin
            left_d = 2'd0;
            fill_d = 2'd0;
            dec_en = 1'b1;
          end else begin
            mode_d = MODE_DATA;
            fill_d = 2'd2;
            left_d = 2'd1;
          end
        end
      end
    endcase
  end

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      left_q <= 2'd0;
      fill_q <= 2'd0;
      rs_q   <= 8'd0;
    end else if (advance) begin
      mode_q <= mode_d;
      left_q <= left_d;
      fill_q <= fill_d;
      rs_q   <= rs_d;
    end
  end

  // message buffer
  always_ff @(posedge clk_i) begin
    if (advance) begin
      buf_q <= buf_d;
    end
  end

  midi_mp_decode u_decode (
    .status_i   (buf_d[0]),
    .data1_i    (buf_d[1]),
    .data2_i    (buf_d[2]),
    .synth_id_i (synth_q),
    .hit_o      (dec_hit),
    .event_o    (dec_ev)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = dec_en && dec_hit;
    end else if (ev_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ev_q <= dec_ev;
    end
  end

  // output channel
  assign ev_o.valid       = out_valid_q;
  assign ev_o.synth_tag   = out_ev_q.synth_tag;
  assign ev_o.event_kind  = out_ev_q.event_kind;
  assign ev_o.channel     = out_ev_q.channel;
  assign ev_o.first_data  = out_ev_q.first_data;
  assign ev_o.event_value = out_ev_q.event_value;

endmodule

`default_nettype wire

@@ hw/rtl/midi_mp_checker.sv @@
// ----------------------------------------------------------------------------
// MIDI parser port checker
// Port-level checks on the parser core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_input_message_parser_core_assert.svh"

module midi_mp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [7:0]  cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  synth_tag_i,
  input logic [2:0]  event_kind_i,
  input logic [7:0]  first_data_i,
  input logic [13:0] event_value_i
);
  import midi_mp_pkg::*;

  logic [7:0] tag_q;

  // shadow of the synth id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= 8'd0;
    end else if (cfg_we_i) begin
      tag_q <= cfg_wdata_i;
    end
  end

  // a rising event valid must trace back to an accepted input byte
  `MIDI_MP_ASSERT_IMP(a_event_from_byte, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

  // stalled event holds
  `MIDI_MP_ASSERT_NXT(a_event_hold, out_valid_i && !out_ready_i,
                      out_valid_i && $stable(synth_tag_i) && $stable(event_kind_i) &&
                      $stable(first_data_i) && $stable(event_value_i))

  // only bend carries a 14-bit value, and bend has no first data byte
  `MIDI_MP_ASSERT_IMP(a_event_fields, out_valid_i,
                      (event_kind_i == KIND_BEND) ? (first_data_i == 8'd0) : (event_value_i[13:8] == 6'd0))

  // every event carries the configured synth id
  `MIDI_MP_ASSERT_IMP(a_event_tag, out_valid_i, synth_tag_i == tag_q)

endmodule

bind midi_input_message_parser_core midi_mp_checker u_midi_mp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .in_valid_i    (rx_i.valid),
  .in_ready_i    (rx_i.ready),
  .out_valid_i   (ev_o.valid),
  .out_ready_i   (ev_o.ready),
  .synth_tag_i   (ev_o.synth_tag),
  .event_kind_i  (ev_o.event_kind),
  .first_data_i  (ev_o.first_data),
  .event_value_i (ev_o.event_value)
);

`default_nettype wire
